// ----- rtl/cre_pkg.sv -----
// Package for the constant register encoder: transaction types, codes and
// the constant table functions. No dependencies.
package cre_pkg;

   // Operation codes of a request
   localparam logic OP_FIND = 1'b0;
   localparam logic OP_READ = 1'b1;

   // Control register indexes
   localparam logic CSR_CONST_OPT_ENABLE = 1'b0;
   localparam logic CSR_TABLE_LAYOUT     = 1'b1;

   // Table layouts
   localparam logic LAYOUT_SMALL = 1'b0;
   localparam logic LAYOUT_LARGE = 1'b1;

   typedef struct packed {
      logic              op;
      logic signed [31:0] value;
      logic [7:0]        reg_index;
   } query_type;

   typedef struct packed {
      logic const_opt_enable;
      logic table_layout;
   } cfg_type;

   typedef struct packed {
      logic              found;
      logic [7:0]        reg_number;
      logic              is_const_reg;
      logic signed [31:0] const_value;
   } result_type;

   // Index of the set bit of a one-hot word
   function automatic logic [4:0] onehot_index(input logic [31:0] x);
      logic [4:0] idx;
      idx = '0;
      for (int i = 0; i < 32; i++) begin
         if (x[i]) begin
            idx = idx | 5'(i);
         end
      end
      return idx;
   endfunction

   // 128-entry layout
   function automatic logic [31:0] entry_small(input logic [7:0] r);
      logic [4:0]  mag;
      logic [5:0]  k;
      logic [31:0] pw;
      logic [3:0]  sh;
      mag = 5'({1'b0, r[4:1]}) + 5'd1;
      k   = 6'(r - 8'd64);
      pw  = 32'h20 << k[5:1];
      sh  = 4'(r - 8'd118);
      if (r < 8'd32 || r[7]) begin
         return '0;
      end else if (r < 8'd64) begin
         // +1, -1, +2, -2 ... +16, -16
         return r[0] ? (32'd0 - {27'd0, mag}) : {27'd0, mag};
      end else if (r < 8'd118) begin
         // 2^k - 1, 2^k pairs
         return r[0] ? pw : (pw - 32'd1);
      end else begin
         // inverted single bits 4..13
         return ~(32'h10 << sh);
      end
   endfunction

   // 256-entry layout
   function automatic logic [31:0] entry_large(input logic [7:0] r);
      logic [4:0]  s;
      logic [31:0] m;
      s = r[4:0];
      m = r[6] ? (32'hffff_ffff >> (5'd31 - s)) : (32'h1 << s);
      if (r < 8'd32) begin
         return '0;
      end else if (r < 8'd80) begin
         return {24'd0, r - 8'd31};
      end else if (r < 8'd128) begin
         return 32'd0 - {24'd0, r - 8'd79};
      end else begin
         return r[5] ? ~m : m;
      end
   endfunction

endpackage

// ----- rtl/cre_req_if.sv -----
// Request channel of the constant register encoder.
// Depends on nothing.
interface cre_req_if;
   logic              valid;
   logic              ready;
   logic              op;
   logic signed [31:0] value;
   logic [7:0]        reg_index;

   modport source (output valid, output op, output value, output reg_index, input ready);
   modport sink   (input valid, input op, input value, input reg_index, output ready);
endinterface

// ----- rtl/cre_rsp_if.sv -----
// Response channel of the constant register encoder.
// Depends on nothing.
interface cre_rsp_if;
   logic              valid;
   logic              ready;
   logic              found;
   logic [7:0]        reg_number;
   logic              is_const_reg;
   logic signed [31:0] const_value;

   modport source (output valid, output found, output reg_number, output is_const_reg,
                   output const_value, input ready);
   modport sink   (input valid, input found, input reg_number, input is_const_reg,
                   input const_value, output ready);
endinterface

// ----- rtl/constant_register_encoder.sv -----
// Top level of the constant register encoder: request register, lookup logic
// and response register. Depends on cre_pkg, cre_req_if, cre_rsp_if, cre_core.
//
// Each request transaction is either a value lookup (op 0: lowest constant
// register holding the value) or a register read (op 1: whether the register
// holds a constant, and which). One transaction is accepted per cycle while the
// pipeline is not held. The request register loads on acceptance and the lookup
// logic feeds the response register from it, whose output is the response. The
// only thing that holds the pipeline is a response that is not taken. The control
// registers are written through the csr_ port and should change only while no
// transaction is in flight.
module constant_register_encoder
   import cre_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   cre_req_if.sink   req_ch,
   cre_rsp_if.source rsp_ch,
   input  logic  csr_write_enable,
   input  logic  csr_index,
   input  logic  csr_write_data
);

   cfg_type    cfg_ff, cfg_in;
   logic       s1_valid_ff, s1_valid_in;
   query_type  s1_query_ff, s1_query_in;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_result_ff, rsp_result_in;
   result_type core_result;
   logic       s2_load, s1_free, req_take;

   // Pipeline flow control
   assign s2_load      = !rsp_valid_ff || rsp_ch.ready;
   assign s1_free      = !s1_valid_ff || s2_load;
   assign req_take     = req_ch.valid && s1_free;
   assign req_ch.ready = s1_free;

   cre_core u_core (
      .query  (s1_query_ff),
      .cfg    (cfg_ff),
      .result (core_result)
   );

   // Next-state values
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_CONST_OPT_ENABLE: cfg_in.const_opt_enable = csr_write_data;
            CSR_TABLE_LAYOUT:     cfg_in.table_layout     = csr_write_data;
            default:              cfg_in = cfg_ff;
         endcase
      end
      s1_valid_in   = s1_free ? req_ch.valid : s1_valid_ff;
      s1_query_in   = req_take ? query_type'{op: req_ch.op, value: req_ch.value,
                                             reg_index: req_ch.reg_index} : s1_query_ff;
      rsp_valid_in  = s2_load ? s1_valid_ff : rsp_valid_ff;
      rsp_result_in = (s2_load && s1_valid_ff) ? core_result : rsp_result_ff;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '{const_opt_enable: 1'b1, table_layout: LAYOUT_LARGE};
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      s1_query_ff   <= s1_query_in;
      rsp_result_ff <= rsp_result_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.found        = rsp_result_ff.found;
   assign rsp_ch.reg_number   = rsp_result_ff.reg_number;
   assign rsp_ch.is_const_reg = rsp_result_ff.is_const_reg;
   assign rsp_ch.const_value  = rsp_result_ff.const_value;

endmodule

// ----- rtl/cre_core.sv -----
// Lookup logic of the constant register encoder: value to register and
// register to value. Depends on cre_pkg.
module cre_core
   import cre_pkg::*;
(
   input  query_type  query,
   input  cfg_type    cfg,
   output result_type result
);

   logic [31:0] v;
   logic [31:0] nv;
   logic [31:0] mag;
   logic        pow2_v, pow2_n, fill_v, fill_n;
   logic [4:0]  bit_v, bit_n, top_v, top_n;
   logic        pos16, neg16, pos48, neg48;
   logic        hit_small, hit_large;
   logic [7:0]  reg_small, reg_large;
   logic        in_range;

   // Shape of the value and of its inversion
   always_comb begin
      v      = query.value;
      nv     = ~v;
      mag    = 32'd0 - v;
      pow2_v = (v != '0) && ((v & (v - 32'd1)) == '0);
      pow2_n = (nv != '0) && ((nv & (nv - 32'd1)) == '0);
      fill_v = (v != '0) && ((v & (v + 32'd1)) == '0);
      fill_n = (nv != '0) && ((nv & (nv + 32'd1)) == '0);
      bit_v  = onehot_index(v);
      bit_n  = onehot_index(nv);
      top_v  = onehot_index(v ^ (v >> 1));
      top_n  = onehot_index(nv ^ (nv >> 1));
      pos16  = (query.value >= 32'sd1) && (query.value <= 32'sd16);
      neg16  = (query.value <= -32'sd1) && (query.value >= -32'sd16);
      pos48  = (query.value >= 32'sd1) && (query.value <= 32'sd48);
      neg48  = (query.value <= -32'sd1) && (query.value >= -32'sd48);
   end

   // 128-entry layout: ranges in ascending register order, first hit wins
   always_comb begin
      hit_small = 1'b1;
      priority if (pos16) begin
         reg_small = 8'd30 + {v[6:0], 1'b0};
      end else if (neg16) begin
         reg_small = 8'd31 + {mag[6:0], 1'b0};
      end else if (pow2_v && bit_v >= 5'd5) begin
         reg_small = 8'd55 + {2'b00, bit_v, 1'b0};
      end else if (fill_v && top_v >= 5'd4 && top_v <= 5'd30) begin
         reg_small = 8'd56 + {2'b00, top_v, 1'b0};
      end else if (pow2_n && bit_n >= 5'd4 && bit_n <= 5'd13) begin
         reg_small = 8'd114 + {3'b000, bit_n};
      end else begin
         hit_small = 1'b0;
         reg_small = '0;
      end
   end

   // 256-entry layout: same ordering rule
   always_comb begin
      hit_large = 1'b1;
      priority if (pos48) begin
         reg_large = v[7:0] + 8'd31;
      end else if (neg48) begin
         reg_large = mag[7:0] + 8'd79;
      end else if (pow2_v) begin
         reg_large = 8'd128 + {3'b000, bit_v};
      end else if (pow2_n) begin
         reg_large = 8'd160 + {3'b000, bit_n};
      end else if (fill_v) begin
         reg_large = 8'd192 + {3'b000, top_v};
      end else if (fill_n) begin
         reg_large = 8'd224 + {3'b000, top_n};
      end else begin
         hit_large = 1'b0;
         reg_large = '0;
      end
   end

   // Result assembly
   always_comb begin
      result   = '0;
      in_range = (query.reg_index == 8'd0) ||
                 (query.reg_index >= 8'd32 &&
                  (cfg.table_layout == LAYOUT_LARGE || !query.reg_index[7]));
      unique case (query.op)
         OP_FIND: begin
            if (cfg.const_opt_enable) begin
               if (v == '0) begin
                  result.found = 1'b1;
               end else if (cfg.table_layout == LAYOUT_LARGE) begin
                  result.found      = hit_large;
                  result.reg_number = reg_large;
               end else begin
                  result.found      = hit_small;
                  result.reg_number = reg_small;
               end
            end
         end
         OP_READ: begin
            if (in_range) begin
               result.is_const_reg = 1'b1;
               result.const_value  = (cfg.table_layout == LAYOUT_LARGE) ?
                                     entry_large(query.reg_index) :
                                     entry_small(query.reg_index);
            end
         end
         default: result = '0;
      endcase
   end

endmodule

// ----- rtl/cre_checker.sv -----
// Port-level checks for the constant register encoder, bound to its top level.
// Depends on constant_register_encoder and its response channel interface.
module cre_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              found,
   input logic [7:0]        reg_number,
   input logic              is_const_reg,
   input logic signed [31:0] const_value
);

   // Nothing comes out right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A lookup response and a read response never mix
   a_op_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(found && is_const_reg))
      else $error("found and is_const_reg both set");

   // Lookup register is 0 when not found, and otherwise 0 or a constant register
   a_reg_number: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (found || reg_number == 8'd0) && (reg_number == 8'd0 || reg_number >= 8'd32))
      else $error("bad reg_number");

   // Non-constant registers read as zero
   a_const_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !is_const_reg |-> const_value == 32'sd0)
      else $error("const_value set for non-constant register");

   // A stalled response holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(found) && $stable(reg_number) &&
      $stable(is_const_reg) && $stable(const_value))
      else $error("stalled response changed");

endmodule

bind constant_register_encoder cre_checker u_cre_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .found        (rsp_ch.found),
   .reg_number   (rsp_ch.reg_number),
   .is_const_reg (rsp_ch.is_const_reg),
   .const_value  (rsp_ch.const_value)
);
